// ----- hdl/slfr_pkg.sv -----
`default_nettype none

package slfr_pkg;

   // Frame receiver phases.
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_CMD  = 2'd1,
      PH_LEN  = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_MATCH    = 2'd1,
      KIND_NO_MATCH = 2'd2,
      KIND_ABORT    = 2'd3
   } kind_type;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_MAX_LEN     = 2'd0,
      CSR_TEXT_CMD    = 2'd1,
      CSR_HDR_TIMEOUT = 2'd2,
      CSR_PAY_TIMEOUT = 2'd3
   } csr_index_type;

   localparam int unsigned LEN_W  = 10;
   localparam int unsigned TICK_W = 16;
   localparam int unsigned CSR_W  = 16;

   localparam logic [LEN_W-1:0]  RESET_MAX_LEN     = 10'd512;
   localparam logic [7:0]        RESET_TEXT_CMD    = 8'h21;
   localparam logic [TICK_W-1:0] RESET_HDR_TIMEOUT = 16'd200;
   localparam logic [TICK_W-1:0] RESET_PAY_TIMEOUT = 16'd500;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_P      = 8'h50;

   localparam logic [2:0] MATCH_LEN = 3'd5;

   typedef struct packed {
      logic [LEN_W-1:0]  max_len;
      logic [7:0]        text_cmd;
      logic [TICK_W-1:0] hdr_timeout;
      logic [TICK_W-1:0] pay_timeout;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] text_length;
      logic             last;
   } result_type;

   // Up to two results from one item; the second is used only with the first.
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } result_pair_type;

   // Characters of the searched text "PONG:".
   function automatic logic [7:0] match_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h50;
         3'd1: c = 8'h4F;
         3'd2: c = 8'h4E;
         3'd3: c = 8'h47;
         3'd4: c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/slfr_parser.sv -----
`default_nettype none

module slfr_parser #(
   parameter int unsigned PAYLOAD_MAX = 512
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_type,
   input  wire logic [7:0]               req_rx_byte,
   input  wire slfr_pkg::cfg_type        cfg,
   input  wire logic                     room,
   output slfr_pkg::result_pair_type     pair
);
   import slfr_pkg::*;

   localparam logic [15:0] PAYLOAD_CAP = 16'(PAYLOAD_MAX);

   logic             item_valid_ff, item_valid_in;
   logic             item_tick_ff;
   logic [7:0]       item_byte_ff;
   logic             advance;

   phase_type         phase_ff, phase_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic              len_half_ff, len_half_in;
   logic [7:0]        len_low_ff, len_low_in;
   logic [LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [2:0]        progress_ff, progress_in;
   logic              seen_ff, seen_in;
   logic [LEN_W-1:0]  trim_ff, trim_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   logic [TICK_W-1:0] limit;
   logic              timed_out;
   logic [15:0]       full_len;
   logic [15:0]       len_cap;
   logic              len_ok;
   logic              is_text;
   logic [LEN_W-1:0]  count_next;
   logic [2:0]        progress_step;
   logic              frame_done;

   assign advance   = item_valid_ff && room;
   assign req_ready = !item_valid_ff || room;

   always_comb begin
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_valid && req_ready) begin
         item_tick_ff <= req_type;
         item_byte_ff <= req_rx_byte;
      end
   end

   // Shared decode of the item held in the input register.
   always_comb begin
      limit     = (phase_ff == PH_DATA) ? cfg.pay_timeout : cfg.hdr_timeout;
      timed_out = ({1'b0, tick_ff} + 17'd1) >= {1'b0, limit};
      full_len  = {item_byte_ff, len_low_ff};
      len_cap   = ({6'd0, cfg.max_len} > PAYLOAD_CAP) ? PAYLOAD_CAP : {6'd0, cfg.max_len};
      len_ok    = (full_len != 16'd0) && (full_len <= len_cap);
      is_text   = (cmd_ff == cfg.text_cmd);
      count_next = count_ff + 1'b1;
      if (item_byte_ff == match_char(progress_ff)) begin
         progress_step = progress_ff + 3'd1;
      end else if (item_byte_ff == CHAR_P) begin
         progress_step = 3'd1;
      end else begin
         progress_step = 3'd0;
      end
      frame_done = count_next >= frame_len_ff;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         if (item_tick_ff) begin
            if (phase_ff != PH_HUNT && timed_out) begin
               phase_in = PH_HUNT;
            end
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (prev_ff == SYNC_FIRST && item_byte_ff == SYNC_SECOND) begin
                     phase_in = PH_CMD;
                  end
               end
               PH_CMD: begin
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  if (len_half_ff) begin
                     phase_in = len_ok ? PH_DATA : PH_HUNT;
                  end
               end
               PH_DATA: begin
                  if (frame_done) begin
                     phase_in = PH_HUNT;
                  end
               end
               default: phase_in = PH_HUNT;
            endcase
         end
      end
   end

   // Frame registers and results.
   always_comb begin
      prev_in      = prev_ff;
      cmd_in       = cmd_ff;
      len_half_in  = len_half_ff;
      len_low_in   = len_low_ff;
      frame_len_in = frame_len_ff;
      count_in     = count_ff;
      progress_in  = progress_ff;
      seen_in      = seen_ff;
      trim_in      = trim_ff;
      tick_in      = tick_ff;
      pair         = '0;
      pair.first.kind  = KIND_DATA;
      pair.second.kind = KIND_DATA;
      if (advance) begin
         if (item_tick_ff) begin
            if (phase_ff != PH_HUNT) begin
               if (timed_out) begin
                  tick_in = '0;
                  if (phase_ff == PH_DATA && is_text) begin
                     pair.first_valid = 1'b1;
                     pair.first.kind  = KIND_ABORT;
                     pair.first.last  = 1'b1;
                  end
               end else begin
                  tick_in = tick_ff + 1'b1;
               end
            end
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  prev_in = item_byte_ff;
                  if (prev_ff == SYNC_FIRST && item_byte_ff == SYNC_SECOND) begin
                     tick_in = '0;
                  end
               end
               PH_CMD: begin
                  cmd_in      = item_byte_ff;
                  len_half_in = 1'b0;
                  tick_in     = '0;
               end
               PH_LEN: begin
                  if (!len_half_ff) begin
                     len_low_in  = item_byte_ff;
                     len_half_in = 1'b1;
                  end else if (len_ok) begin
                     frame_len_in = full_len[LEN_W-1:0];
                     count_in     = '0;
                     progress_in  = '0;
                     seen_in      = 1'b0;
                     trim_in      = '0;
                     tick_in      = '0;
                  end
               end
               PH_DATA: begin
                  count_in = count_next;
                  if (item_byte_ff != CHAR_LF && item_byte_ff != CHAR_CR) begin
                     trim_in = count_next;
                  end
                  if (progress_step == MATCH_LEN) begin
                     seen_in     = 1'b1;
                     progress_in = '0;
                  end else begin
                     progress_in = progress_step;
                  end
                  if (is_text) begin
                     pair.first_valid     = 1'b1;
                     pair.first.data_byte = item_byte_ff;
                  end
                  if (frame_done) begin
                     tick_in = '0;
                     if (is_text) begin
                        pair.second_valid       = 1'b1;
                        pair.second.kind        = seen_in ? KIND_MATCH : KIND_NO_MATCH;
                        pair.second.text_length = trim_in;
                        pair.second.last        = 1'b1;
                     end
                  end
               end
               default: begin
                  tick_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         prev_ff      <= '0;
         cmd_ff       <= '0;
         len_half_ff  <= 1'b0;
         len_low_ff   <= '0;
         frame_len_ff <= '0;
         count_ff     <= '0;
         progress_ff  <= '0;
         seen_ff      <= 1'b0;
         trim_ff      <= '0;
         tick_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         cmd_ff       <= cmd_in;
         len_half_ff  <= len_half_in;
         len_low_ff   <= len_low_in;
         frame_len_ff <= frame_len_in;
         count_ff     <= count_in;
         progress_ff  <= progress_in;
         seen_ff      <= seen_in;
         trim_ff      <= trim_in;
         tick_ff      <= tick_in;
      end
   end

   // A verdict always closes the frame and follows its last data byte.
   assert property (@(posedge clock) disable iff (reset)
      pair.second_valid |-> pair.second.last && pair.first_valid
                            && pair.first.kind == KIND_DATA)
      else $error("verdict without a preceding data byte");

   // Nothing is reported while hunting for sync.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> !pair.first_valid)
      else $error("result while hunting");

endmodule

`default_nettype wire

// ----- hdl/slfr_rsp_queue.sv -----
`default_nettype none

module slfr_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire slfr_pkg::result_pair_type pair,
   output logic                          room,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output slfr_pkg::result_type          head
);
   import slfr_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   push_count;
   logic               pop;

   // The producer may hand over a pair only when two slots are free.
   assign room      = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = entry_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      push_count = CNT_W'(pair.first_valid) + CNT_W'(pair.second_valid);
      wr_in      = wr_ff + PTR_W'(push_count);
      rd_in      = rd_ff + PTR_W'(pop);
      count_in   = count_ff + push_count - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (pair.first_valid) begin
         entry_ff[wr_ff] <= pair.first;
      end
      if (pair.second_valid) begin
         entry_ff[wr_ff + PTR_W'(1)] <= pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pair.first_valid |-> room)
      else $error("results pushed without room");

   assert property (@(posedge clock) disable iff (reset)
      pair.second_valid |-> pair.first_valid)
      else $error("second result without first");

endmodule

`default_nettype wire

// ----- hdl/sync_length_frame_receiver.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_type, req_rx_byte
// rsp       out        rsp_valid/rsp_ready    rsp_kind, rsp_data_byte, rsp_text_length, rsp_last
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// One item per cycle while the queue has room: an accepted item is decoded from the
// input register and its zero, one or two results enter a four-entry result queue.
// The queue sets the rate: a new item moves on while at least two slots are free.
// Reset is synchronous and restores the register defaults and the hunting phase.
// A stall on rsp holds results in the queue and then holds req_ready low.

module sync_length_frame_receiver #(
   parameter int unsigned PAYLOAD_MAX = 512
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_type,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_data_byte,
   output logic [slfr_pkg::LEN_W-1:0]          rsp_text_length,
   output logic                                rsp_last,
   input  wire logic                           csr_write_enable,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [slfr_pkg::CSR_W-1:0]     csr_write_data
);
   import slfr_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   result_pair_type pair;
   result_type      head;
   logic            room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_LEN:     cfg_in.max_len     = csr_write_data[LEN_W-1:0];
            CSR_TEXT_CMD:    cfg_in.text_cmd    = csr_write_data[7:0];
            CSR_HDR_TIMEOUT: cfg_in.hdr_timeout = csr_write_data[TICK_W-1:0];
            CSR_PAY_TIMEOUT: cfg_in.pay_timeout = csr_write_data[TICK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_len     <= RESET_MAX_LEN;
         cfg_ff.text_cmd    <= RESET_TEXT_CMD;
         cfg_ff.hdr_timeout <= RESET_HDR_TIMEOUT;
         cfg_ff.pay_timeout <= RESET_PAY_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slfr_parser #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .room        (room),
      .pair        (pair)
   );

   slfr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_text_length = head.text_length;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire
